[src/rit_pkg.sv]
// shared types, widths and register codes of the reprojection inlier test
// used by every module of the block; depends on nothing
package rit_pkg;

    localparam int PT_W    = 24;  // point and pixel fields
    localparam int ROT_W   = 20;  // rotation entry Q2.18
    localparam int TR_W    = 20;  // translation entry Q8.12
    localparam int CAL_W   = 21;  // calibration entry Q13.8
    localparam int ROW_W   = 60;  // packed rotation/translation register
    localparam int CROW_W  = 63;  // packed calibration register
    localparam int CFG_W   = 63;  // configuration write data
    localparam int LIM_W   = 40;  // squared error Q32.8
    localparam int CAM_W   = 48;  // camera coordinate, 34 fraction bits
    localparam int PROD_W  = ROT_W + PT_W;
    localparam int TR_SH   = 22;
    localparam int DIV_LOW = 15;  // integer quotient limit 2^15
    localparam int N_FRAC  = 24;
    localparam int QUO_W   = 39;
    localparam int NRM_W   = 40;
    localparam int KM_W    = CAL_W + NRM_W;
    localparam int ACC_W   = 63;
    localparam int RND_W   = ACC_W - N_FRAC;
    localparam int EU_W    = RND_W + 2;
    localparam int ERR_W   = 25;
    localparam int SQE_W   = 2 * ERR_W;
    localparam int IN_W    = 5 * PT_W;
    localparam int OUT_W   = 48;

    localparam logic [QUO_W-1:0] N_SAT     = {QUO_W{1'b1}};
    localparam logic [ERR_W-1:0] ERR_SAT   = ERR_W'(1) << (ERR_W - 1);
    localparam logic [LIM_W-1:0] SQ_MAX    = {LIM_W{1'b1}};
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(6400);

    typedef logic signed [CAM_W-1:0] cam_t;
    typedef logic signed [NRM_W-1:0] nrm_t;
    typedef logic signed [PT_W-1:0]  pt_t;

    typedef struct packed {
        pt_t obs_u;
        pt_t obs_v;
    } obs_t;

    typedef struct packed {
        logic front;
        pt_t  obs_u;
        pt_t  obs_v;
    } side_t;

    typedef enum logic [2:0] {
        REG_ROT0  = 3'd0,
        REG_ROT1  = 3'd1,
        REG_ROT2  = 3'd2,
        REG_TRANS = 3'd3,
        REG_CAL0  = 3'd4,
        REG_CAL1  = 3'd5,
        REG_LIMIT = 3'd6
    } cfg_index_t;

endpackage

[src/rit_transform.sv]
// rigid transform of a world point into camera space, two register stages
// depends on rit_pkg
module rit_transform (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  rit_pkg::pt_t             point_x,
    input  rit_pkg::pt_t             point_y,
    input  rit_pkg::pt_t             point_z,
    input  rit_pkg::obs_t            obs_in,
    input  logic [rit_pkg::ROW_W-1:0] rot0,
    input  logic [rit_pkg::ROW_W-1:0] rot1,
    input  logic [rit_pkg::ROW_W-1:0] rot2,
    input  logic [rit_pkg::ROW_W-1:0] trans,
    output logic                     out_valid,
    output rit_pkg::cam_t            cx,
    output rit_pkg::cam_t            cy,
    output rit_pkg::cam_t            cz,
    output rit_pkg::obs_t            obs_out
);
    import rit_pkg::*;

    logic [ROW_W-1:0]         rot [3];
    pt_t                      pt [3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    cam_t                     tsh_next [3];
    cam_t                     tsh_reg [3];
    cam_t                     cam_next [3];
    cam_t                     cam_reg [3];
    obs_t                     obs_a_reg, obs_b_reg;
    logic                     va_reg, vb_reg;

    assign rot[0] = rot0;
    assign rot[1] = rot1;
    assign rot[2] = rot2;
    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;

    // stage a: nine products and the scaled translation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[r][j] = $signed(rot[r][ROT_W*j +: ROT_W]) * pt[j];
            end
            tsh_next[r] = {{(CAM_W-TR_W-TR_SH){trans[TR_W*r+TR_W-1]}},
                           trans[TR_W*r +: TR_W], {TR_SH{1'b0}}};
        end
    end

    // stage b: row sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cam_next[r] = tsh_reg[r]
                + {{(CAM_W-PROD_W){prod_reg[r][0][PROD_W-1]}}, prod_reg[r][0]}
                + {{(CAM_W-PROD_W){prod_reg[r][1][PROD_W-1]}}, prod_reg[r][1]}
                + {{(CAM_W-PROD_W){prod_reg[r][2][PROD_W-1]}}, prod_reg[r][2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= prod_next;
            tsh_reg   <= tsh_next;
            obs_a_reg <= obs_in;
            cam_reg   <= cam_next;
            obs_b_reg <= obs_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign cx        = cam_reg[0];
    assign cy        = cam_reg[1];
    assign cz        = cam_reg[2];
    assign obs_out   = obs_b_reg;

endmodule

[src/rit_divider.sv]
// pipelined restoring divider, one quotient bit per stage, two lanes (x and y by depth)
// depends on rit_pkg
module rit_divider (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  rit_pkg::cam_t cx,
    input  rit_pkg::cam_t cy,
    input  rit_pkg::cam_t cz,
    input  rit_pkg::obs_t obs_in,
    output logic          out_valid,
    output rit_pkg::nrm_t nx,
    output rit_pkg::nrm_t ny,
    output rit_pkg::side_t side_out
);
    import rit_pkg::*;

    localparam int NST = QUO_W + 1;

    logic [CAM_W-1:0] rem_reg [NST][2];
    logic [QUO_W-1:0] low_reg [NST][2];
    logic [QUO_W-1:0] quo_reg [NST][2];
    logic             sgn_reg [NST][2];
    logic             ovf_reg [NST][2];
    logic [CAM_W-1:0] den_reg [NST];
    side_t            side_reg [NST];
    logic             v_reg [NST];

    cam_t             num [2];
    logic [CAM_W-1:0] mag [2];
    logic [CAM_W-1:0] den0;
    nrm_t             n_reg [2];
    side_t            side_o_reg;
    logic             vo_reg;

    assign num[0] = cx;
    assign num[1] = cy;
    assign den0   = cz;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag[l] = num[l][CAM_W-1] ? CAM_W'(-num[l]) : CAM_W'(num[l]);
        end
    end

    // prep stage: magnitude, overflow test and the first partial remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                sgn_reg[0][l] <= num[l][CAM_W-1];
                ovf_reg[0][l] <= {{DIV_LOW{1'b0}}, mag[l]} >= {den0, {DIV_LOW{1'b0}}};
                rem_reg[0][l] <= {{DIV_LOW{1'b0}}, mag[l][CAM_W-1:DIV_LOW]};
                low_reg[0][l] <= {mag[l][DIV_LOW-1:0], {N_FRAC{1'b0}}};
                quo_reg[0][l] <= '0;
            end
            den_reg[0]  <= den0;
            side_reg[0] <= '{front: (cz > 0), obs_u: obs_in.obs_u, obs_v: obs_in.obs_v};
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k < NST; k++) begin : g_step
        logic [CAM_W:0]   trial [2];
        logic             ge [2];
        logic [CAM_W-1:0] rem_next [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                trial[l]    = {rem_reg[k-1][l], low_reg[k-1][l][QUO_W-1]};
                ge[l]       = trial[l] >= {1'b0, den_reg[k-1]};
                rem_next[l] = ge[l] ? CAM_W'(trial[l] - {1'b0, den_reg[k-1]})
                                    : trial[l][CAM_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k][l] <= rem_next[l];
                    low_reg[k][l] <= {low_reg[k-1][l][QUO_W-2:0], 1'b0};
                    quo_reg[k][l] <= {quo_reg[k-1][l][QUO_W-2:0], ge[l]};
                    sgn_reg[k][l] <= sgn_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // saturate and restore the sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (adv) begin
            vo_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                logic [NRM_W-1:0] q;
                q = {1'b0, ovf_reg[NST-1][l] ? N_SAT : quo_reg[NST-1][l]};
                n_reg[l] <= sgn_reg[NST-1][l] ? -q : q;
            end
            side_o_reg <= side_reg[NST-1];
        end
    end

    assign out_valid = vo_reg;
    assign nx        = n_reg[0];
    assign ny        = n_reg[1];
    assign side_out  = side_o_reg;

endmodule

[src/rit_project.sv]
// calibration projection, rounding, squared error and threshold test
// depends on rit_pkg; its last stage is the block's output register
module rit_project (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  rit_pkg::nrm_t              nx,
    input  rit_pkg::nrm_t              ny,
    input  rit_pkg::side_t             side_in,
    input  logic [rit_pkg::CROW_W-1:0] cal0,
    input  logic [rit_pkg::CROW_W-1:0] cal1,
    input  logic [rit_pkg::LIM_W-1:0]  limit,
    output logic                       out_valid,
    output logic                       is_inlier,
    output logic                       in_front,
    output logic [rit_pkg::LIM_W-1:0]  squared_error
);
    import rit_pkg::*;

    logic [CROW_W-1:0]      cal [2];
    logic signed [KM_W-1:0] km_reg [2][3];
    logic signed [ACC_W-1:0] acc_reg [2];
    logic [RND_W-1:0]       rnd_reg [2];
    logic                   neg_reg [2];
    logic signed [EU_W-1:0] eu_reg [2];
    logic [ERR_W-1:0]       ea_reg [2];
    logic [SQE_W-1:0]       esq_reg [2];
    logic [LIM_W-1:0]       sq_reg;
    side_t                  side_reg [7];
    logic                   v_reg [7];
    logic                   inl_o_reg, front_o_reg, vo_reg;
    logic [LIM_W-1:0]       sq_o_reg;
    logic [SQE_W+1:0]       total;

    assign cal[0] = cal0;
    assign cal[1] = cal1;

    // valid and side data travel with the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 7; s++) begin
                v_reg[s] <= 1'b0;
            end
            vo_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < 7; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
            vo_reg <= v_reg[6];
        end
    end

    assign total = {2'b0, esq_reg[0]} + {2'b0, esq_reg[1]} + (SQE_W+2)'(128);

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_in;
            for (int s = 1; s < 7; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int r = 0; r < 2; r++) begin
                logic signed [ACC_W-1:0] m;
                logic [ACC_W-1:0]        a;
                logic signed [EU_W-1:0]  pix;
                logic signed [EU_W-1:0]  ob;
                logic [EU_W-1:0]         ae;
                // products with the normalized coordinates
                km_reg[r][0] <= $signed(cal[r][0 +: CAL_W]) * nx;
                km_reg[r][1] <= $signed(cal[r][CAL_W +: CAL_W]) * ny;
                km_reg[r][2] <= {{(KM_W-CAL_W-N_FRAC){cal[r][3*CAL_W-1]}},
                                 cal[r][2*CAL_W +: CAL_W], {N_FRAC{1'b0}}};
                // row sum
                acc_reg[r] <= {{(ACC_W-KM_W){km_reg[r][0][KM_W-1]}}, km_reg[r][0]}
                            + {{(ACC_W-KM_W){km_reg[r][1][KM_W-1]}}, km_reg[r][1]}
                            + {{(ACC_W-KM_W){km_reg[r][2][KM_W-1]}}, km_reg[r][2]};
                // round half away from zero
                m = acc_reg[r];
                a = m[ACC_W-1] ? ACC_W'(-m) : ACC_W'(m);
                a = a + (ACC_W'(1) << (N_FRAC - 1));
                rnd_reg[r] <= a[ACC_W-1:N_FRAC];
                neg_reg[r] <= m[ACC_W-1];
                // pixel error
                pix = {2'b0, rnd_reg[r]};
                if (neg_reg[r]) begin
                    pix = -pix;
                end
                ob = (r == 0) ? EU_W'(side_reg[2].obs_u) : EU_W'(side_reg[2].obs_v);
                eu_reg[r] <= pix - ob;
                // magnitude, saturated
                ae = eu_reg[r][EU_W-1] ? EU_W'(-eu_reg[r]) : EU_W'(eu_reg[r]);
                ea_reg[r] <= (ae > EU_W'(ERR_SAT)) ? ERR_SAT : ae[ERR_W-1:0];
                esq_reg[r] <= ea_reg[r] * ea_reg[r];
            end
            // sum, scale and saturate
            sq_reg <= (total[SQE_W+1:8] > (SQE_W-6)'(SQ_MAX)) ? SQ_MAX
                                                              : LIM_W'(total[SQE_W+1:8]);
            // output register
            front_o_reg <= side_reg[6].front;
            inl_o_reg   <= side_reg[6].front && (sq_reg <= limit);
            sq_o_reg    <= side_reg[6].front ? sq_reg : SQ_MAX;
        end
    end

    assign out_valid     = vo_reg;
    assign is_inlier     = inl_o_reg;
    assign in_front      = front_o_reg;
    assign squared_error = sq_o_reg;

endmodule

[src/reprojection_inlier_test.sv]
// Pinhole reprojection inlier test. Each transaction on s_ carries a world
// point and its observed pixel; one transaction on m_ returns inlier flag,
// in-front flag and the saturated squared pixel error. One point enters per
// clock when m_tready stays high. A point passes 51 register stages in all on its way
// to m_: the 2 transform stages, the 41 stages of the bit-per-stage divider and the 8
// projection/error stages. A stall on m_ holds the whole pipeline. The user must write
// pose, calibration and limit registers through cfg_wr_en/cfg_index/cfg_wdata only
// while no point is in flight; the block itself does not enforce this.
// depends on rit_pkg, rit_transform, rit_divider, rit_project
module reprojection_inlier_test (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // point_x, point_y, point_z, obs_u, obs_v from bit 0 up
    input  logic [rit_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // is_inlier, in_front, squared_error from bit 0 up, zero filled
    output logic [rit_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_index,
    input  logic [rit_pkg::CFG_W-1:0]  cfg_wdata
);
    import rit_pkg::*;

    logic [ROW_W-1:0]  rot0_reg, rot1_reg, rot2_reg, trans_reg;
    logic [CROW_W-1:0] cal0_reg, cal1_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic              adv;
    logic              tv, dv;
    cam_t              cx, cy, cz;
    obs_t              obs_t1;
    nrm_t              nx, ny;
    side_t             side_d;
    logic              inl, front;
    logic [LIM_W-1:0]  sq;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot0_reg  <= '0;
            rot1_reg  <= '0;
            rot2_reg  <= '0;
            trans_reg <= '0;
            cal0_reg  <= '0;
            cal1_reg  <= '0;
            limit_reg <= LIM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROT0:  rot0_reg  <= cfg_wdata[ROW_W-1:0];
                REG_ROT1:  rot1_reg  <= cfg_wdata[ROW_W-1:0];
                REG_ROT2:  rot2_reg  <= cfg_wdata[ROW_W-1:0];
                REG_TRANS: trans_reg <= cfg_wdata[ROW_W-1:0];
                REG_CAL0:  cal0_reg  <= cfg_wdata[CROW_W-1:0];
                REG_CAL1:  cal1_reg  <= cfg_wdata[CROW_W-1:0];
                REG_LIMIT: limit_reg <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves unless a result waits at the output
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    rit_transform u_xform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .point_x  (s_tdata[PT_W-1:0]),
        .point_y  (s_tdata[2*PT_W-1:PT_W]),
        .point_z  (s_tdata[3*PT_W-1:2*PT_W]),
        .obs_in   ('{obs_u: s_tdata[4*PT_W-1:3*PT_W], obs_v: s_tdata[5*PT_W-1:4*PT_W]}),
        .rot0     (rot0_reg),
        .rot1     (rot1_reg),
        .rot2     (rot2_reg),
        .trans    (trans_reg),
        .out_valid(tv),
        .cx       (cx),
        .cy       (cy),
        .cz       (cz),
        .obs_out  (obs_t1)
    );

    rit_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (tv),
        .cx       (cx),
        .cy       (cy),
        .cz       (cz),
        .obs_in   (obs_t1),
        .out_valid(dv),
        .nx       (nx),
        .ny       (ny),
        .side_out (side_d)
    );

    rit_project u_proj (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (dv),
        .nx           (nx),
        .ny           (ny),
        .side_in      (side_d),
        .cal0         (cal0_reg),
        .cal1         (cal1_reg),
        .limit        (limit_reg),
        .out_valid    (m_tvalid),
        .is_inlier    (inl),
        .in_front     (front),
        .squared_error(sq)
    );

    assign m_tdata = {{(OUT_W-LIM_W-2){1'b0}}, sq, front, inl};

endmodule

[src/rit_checker.sv]
// port-level checks of the reprojection inlier test, bound to the top level
// depends on rit_pkg and reprojection_inlier_test
module rit_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rit_pkg::OUT_W-1:0] m_tdata
);
    import rit_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // inlier implies in front
    a_inl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("inlier behind camera");

    // behind camera reports maximum error
    a_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[LIM_W+1:2] == SQ_MAX)
        else $error("behind camera without maximum error");

    // input side stalls exactly when a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind reprojection_inlier_test rit_checker u_rit_checker (.*);

[dv/tb_reprojection_inlier_test.sv]
// self-checking testbench for reprojection_inlier_test: random pose, calibration and points
// predicts each result in fixed point and compares all of its fields; depends on rit_pkg
`timescale 1ns / 1ps

module tb_reprojection_inlier_test;
    import rit_pkg::*;

    localparam logic [39:0] SQ_SAT = 40'hFF_FFFF_FFFF;
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [39:0] sq_err;
        logic        front;
        logic        inlier;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = REG_ROT0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    reprojection_inlier_test DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow copies of the configuration registers
    logic [59:0] rot_m [3];
    logic [59:0] trans_m;
    logic [62:0] cal_m [2];
    logic [39:0] limit_m;

    logic [IN_W-1:0] point_queue[$];
    verdict_t verdict_queue[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;

    // append a point to the pending queue
    function automatic void add_point(logic [IN_W-1:0] d);
        point_queue.insert(point_queue.size(), d);
    endfunction

    // truncating divide with 24 fraction bits, saturated, c_z > 0
    function automatic logic signed [63:0] norm_div(logic signed [63:0] num,
                                                    logic signed [63:0] den);
        logic [63:0] a, q, r;
        a = num < 0 ? -num : num;
        q = a / den;
        r = a % den;
        if (q >= 64'd32768) begin
            q = 64'h7F_FFFF_FFFF;
        end else begin
            for (int i = 0; i < 24; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            if (q > 64'h7F_FFFF_FFFF) q = 64'h7F_FFFF_FFFF;
        end
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] err_square(logic signed [63:0] e);
        logic [63:0] a;
        a = e < 0 ? -e : e;
        if (a > 64'd16777216) a = 64'd16777216;
        return a * a;
    endfunction

    function automatic verdict_t reproject(logic [IN_W-1:0] d);
        logic signed [63:0] p [3];
        logic signed [63:0] c [3];
        logic signed [63:0] n [2];
        logic signed [63:0] pix [2];
        logic signed [63:0] obs [2];
        logic signed [127:0] acc;
        logic [127:0] a;
        logic [63:0] sq;
        verdict_t v;
        for (int j = 0; j < 3; j++) p[j] = $signed(d[j*24 +: 24]);
        obs[0] = $signed(d[72 +: 24]);
        obs[1] = $signed(d[96 +: 24]);
        for (int r = 0; r < 3; r++) begin
            c[r] = $signed(trans_m[r*20 +: 20]) * 64'sd4194304;
            for (int j = 0; j < 3; j++) c[r] += $signed(rot_m[r][j*20 +: 20]) * p[j];
        end
        if (c[2] <= 0) begin
            v.inlier = 1'b0;
            v.front = 1'b0;
            v.sq_err = SQ_SAT;
            return v;
        end
        n[0] = norm_div(c[0], c[2]);
        n[1] = norm_div(c[1], c[2]);
        for (int r = 0; r < 2; r++) begin
            acc = 128'($signed(cal_m[r][20:0])) * n[0] + 128'($signed(cal_m[r][41:21])) * n[1]
                + 128'($signed(cal_m[r][62:42])) * 128'sd16777216;
            a = acc < 0 ? -acc : acc;
            a = (a + 128'd8388608) >> 24;
            pix[r] = acc < 0 ? -$signed(a[63:0]) : $signed(a[63:0]);
        end
        sq = (err_square(pix[0] - obs[0]) + err_square(pix[1] - obs[1]) + 64'd128) >> 8;
        if (sq > SQ_SAT) sq = SQ_SAT;
        v.sq_err = sq[39:0];
        v.front = 1'b1;
        v.inlier = sq[39:0] <= limit_m;
        return v;
    endfunction

    // short gaps mostly, a long one now and then
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: offers queued points, holds s_tvalid across back-to-back transactions
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                verdict_queue.insert(verdict_queue.size(), reproject(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0 || point_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (drv_gap > 0) drv_gap <= drv_gap - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= point_queue.pop_front();
                    drv_gap <= gap_len();
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    int mon_gap = 0;
    always @(posedge aclk) begin
        verdict_t got, exp_v;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[41:0];
                if (verdict_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_v = verdict_queue.pop_front();
                    if (got !== exp_v) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: inlier %b/%b front %b/%b sq %h/%h",
                                     exp_v.inlier, got.inlier, exp_v.front, got.front,
                                     exp_v.sq_err, got.sq_err);
                    end
                end
            end
            // one long hold, counted here, then random gaps
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end else if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_cnt <= 150;
                hold_done <= 1'b1;
            end else if (mon_gap > 0) begin
                m_tready <= 1'b0;
                mon_gap <= mon_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tready) mon_gap <= gap_len();
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [62:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ROT0: rot_m[0] = val[59:0];
            REG_ROT1: rot_m[1] = val[59:0];
            REG_ROT2: rot_m[2] = val[59:0];
            REG_TRANS: trans_m = val[59:0];
            REG_CAL0: cal_m[0] = val;
            REG_CAL1: cal_m[1] = val;
            REG_LIMIT: limit_m = val[39:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        while (point_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [62:0] pack20(int a, int b, int c);
        return 63'({20'(c), 20'(b), 20'(a)});
    endfunction

    function automatic logic [62:0] pack21(int a, int b, int c);
        return {21'(c), 21'(b), 21'(a)};
    endfunction

    function automatic logic [IN_W-1:0] pack_point(int x, int y, int z, int u, int v);
        return {24'(v), 24'(u), 24'(z), 24'(y), 24'(x)};
    endfunction

    function automatic logic [IN_W-1:0] rand_bits();
        return IN_W'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    // near-identity pose with a plausible camera, random content around it
    task automatic sane_setup(logic [39:0] lim);
        write_reg(REG_ROT0, pack20(262144 + $urandom_range(0, 4000) - 2000,
                                   $urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000));
        write_reg(REG_ROT1, pack20($urandom_range(0, 8000) - 4000,
                                   262144 + $urandom_range(0, 4000) - 2000, $urandom_range(0, 8000) - 4000));
        write_reg(REG_ROT2, pack20($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                                   262144 + $urandom_range(0, 4000) - 2000));
        write_reg(REG_TRANS, pack20($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                                    $urandom_range(4096, 40960)));
        write_reg(REG_CAL0, pack21($urandom_range(100000, 200000), 0, $urandom_range(50000, 100000)));
        write_reg(REG_CAL1, pack21(0, $urandom_range(100000, 200000), $urandom_range(40000, 80000)));
        write_reg(REG_LIMIT, 63'(lim));
    endtask

    // point whose observed pixel lies near the offset term of the shadow calibration
    function automatic logic [IN_W-1:0] near_point();
        logic [IN_W-1:0] d;
        int x, y, z;
        x = $urandom_range(0, 400000) - 200000;
        y = $urandom_range(0, 400000) - 200000;
        z = $urandom_range(0, 600000);
        d = pack_point(x, y, z, 0, 0);
        // rough pixel estimate from the calibration, refined by random offset
        d[72 +: 24] = 24'($signed(cal_m[0][62:42]) + $urandom_range(0, 4000) - 2000);
        d[96 +: 24] = 24'($signed(cal_m[1][62:42]) + $urandom_range(0, 4000) - 2000);
        return d;
    endfunction

    initial begin
        rot_m[0] = '0; rot_m[1] = '0; rot_m[2] = '0;
        trans_m = '0; cal_m[0] = '0; cal_m[1] = '0;
        limit_m = 40'd6400;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pose: every point is behind the camera
        add_point(pack_point(1000, -1000, 5000, 0, 0));
        add_point(rand_bits());
        drain_pipe();

        // directed: extremes with identity-like pose
        sane_setup(40'd6400);
        add_point(pack_point(0, 0, 0, 0, 0));
        add_point(pack_point(8388607, 8388607, 8388607, 8388607, 8388607));
        add_point(pack_point(-8388608, -8388608, -8388608, -8388608, -8388608));
        add_point(pack_point(8388607, -8388608, 65536, -8388608, 8388607));
        add_point(pack_point(-8388608, 8388607, 1, 8388607, -8388608));
        add_point(pack_point(0, 0, -8388608, 0, 0));
        for (int i = 0; i < 6; i++) add_point(near_point());
        drain_pipe();

        // extreme registers: saturating division and pixel, limit at max
        write_reg(REG_ROT0, 63'({60{1'b1}} >> 1));
        write_reg(REG_ROT1, 63'({3{20'h80000}}));
        write_reg(REG_ROT2, pack20(0, 0, 1));
        write_reg(REG_TRANS, pack20(-524288, 524287, 1));
        write_reg(REG_CAL0, {3{21'h0FFFFF}});
        write_reg(REG_CAL1, {3{21'h100000}});
        write_reg(REG_LIMIT, 63'(SQ_SAT));
        for (int i = 0; i < 6; i++) add_point(rand_bits());
        add_point(pack_point(8388607, -8388608, 8388607, 0, 0));
        drain_pipe();
        write_reg(REG_LIMIT, 63'd0);
        write_reg(REG_ROT2, 63'({60{1'b1}}));
        for (int i = 0; i < 4; i++) add_point(rand_bits());
        drain_pipe();

        // random phases; one phase holds the receiver off long enough to fill the pipe
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: sane_setup(40'd6400);
                1: sane_setup(40'({$urandom, $urandom}) & 40'hFF_FFFF);
                2: sane_setup(SQ_SAT);
                default: begin
                    write_reg(REG_ROT0, 63'({$urandom, $urandom}));
                    write_reg(REG_ROT1, 63'({$urandom, $urandom}));
                    write_reg(REG_ROT2, 63'({$urandom, $urandom}));
                    write_reg(REG_TRANS, 63'({$urandom, $urandom}));
                    write_reg(REG_CAL0, 63'({$urandom, $urandom}));
                    write_reg(REG_CAL1, 63'({$urandom, $urandom}));
                    write_reg(REG_LIMIT, 63'({$urandom, $urandom}));
                end
            endcase
            for (int i = 0; i < 93; i++)
                add_point($urandom_range(0, 9) < 8 ? near_point() : rand_bits());
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            drain_pipe();
        end

        if (mismatches == 0 && verdict_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/rit_pkg.sv
src/rit_transform.sv
src/rit_divider.sv
src/rit_project.sv
src/reprojection_inlier_test.sv
src/rit_checker.sv
dv/tb_reprojection_inlier_test.sv
